### rtl/gbn_pkg.sv
// Package for the greedy box suppression block: payload structs and sizes.
// No dependencies.
`default_nettype none
package gbn_pkg;
    localparam int MaxBoxes   = 64;
    localparam int CoordBits  = 12;
    localparam int IdxBits    = $clog2(MaxBoxes);
    localparam int CntBits    = $clog2(MaxBoxes + 1);
    localparam int ScoreBits  = 16;
    localparam int ClassBits  = 8;
    localparam int CornerBits = 4 * CoordBits;
    localparam int SlBits     = ScoreBits + ClassBits;
    localparam int SideBits   = CoordBits + 2;
    localparam int AreaBits   = 2 * SideBits;
    localparam int ThrBits    = 16;

    typedef struct packed {
        logic [CoordBits-1:0] left;
        logic [CoordBits-1:0] top;
        logic [CoordBits-1:0] right;
        logic [CoordBits-1:0] bottom;
        logic [ScoreBits-1:0] confidence;
        logic [ClassBits-1:0] class_tag;
        logic                 final_box;
    } t_box_in;

    typedef struct packed {
        logic [IdxBits-1:0]   load_index;
        logic [CoordBits-1:0] kept_left;
        logic [CoordBits-1:0] kept_top;
        logic [CoordBits-1:0] kept_right;
        logic [CoordBits-1:0] kept_bottom;
        logic [ScoreBits-1:0] kept_confidence;
        logic [ClassBits-1:0] kept_class;
        logic                 last_kept;
    } t_box_out;
endpackage
`default_nettype wire

### rtl/greedy_box_nms.sv
// Greedy non-maximum suppression over up to MaxBoxes loaded boxes.
// Depends on gbn_pkg and gbn_ram.
//
// channel  dir  handshake               payload
// box in   in   i_in_valid/o_in_ready   i_in  (gbn_pkg::t_box_in)
// kept     out  o_out_valid/i_out_ready o_out (gbn_pkg::t_box_out)
// thresh   in   i_cfg_valid/o_cfg_ready i_cfg_data (16 bits)
//
// A non-final box is stored and loading goes on. A final box starts suppression:
// each round scans all N entries for the best score through one read port,
// fetches the kept box, then tests every entry against it with the shared box
// multiplier and a threshold multiplier. A result still waiting in the output
// register holds the sequencer at the end of a round. Reset clears control
// state; store contents are undefined until loaded.
`default_nettype none
module greedy_box_nms (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gbn_pkg::t_box_in  i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gbn_pkg::t_box_out      o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [15:0]       i_cfg_data
);
    import gbn_pkg::*;

    localparam logic [2:0] StLoad  = 3'd0;
    localparam logic [2:0] StScan  = 3'd1;
    localparam logic [2:0] StKeep  = 3'd2;
    localparam logic [2:0] StTest  = 3'd3;
    localparam logic [2:0] StEmit  = 3'd4;
    localparam logic [2:0] StDone  = 3'd5;

    logic [2:0]            r_state;
    logic [ThrBits-1:0]    r_thr;
    logic [CntBits-1:0]    r_count;
    logic [MaxBoxes-1:0]   r_supp;
    logic [IdxBits-1:0]    r_idx;
    logic [2:0]            r_ph;
    logic                  r_found;
    logic [IdxBits-1:0]    r_best;
    logic [ScoreBits-1:0]  r_best_score;
    logic [CornerBits-1:0] r_kc;
    logic [SlBits-1:0]     r_ksl;
    logic [AreaBits-1:0]   r_karea;
    logic                  r_pend;
    t_box_out              r_pend_out;
    logic                  r_ov;
    t_box_out              r_out;
    // per-pair working registers
    logic signed [SideBits-1:0] r_iw, r_ih;
    logic [AreaBits-1:0]        r_inter, r_barea;
    logic signed [AreaBits+1:0] r_sum;
    logic [AreaBits+17:0]       r_lhs;

    logic [IdxBits-1:0]    w_raddr;
    logic [CornerBits-1:0] w_c;
    logic [SlBits-1:0]     w_sl;
    logic                  w_we;
    logic [IdxBits-1:0]    w_waddr;
    logic                  w_emit;

    assign w_we    = (r_state == StLoad) && i_in_valid && o_in_ready
                     && (r_count < CntBits'(MaxBoxes));
    assign w_waddr = r_count[IdxBits-1:0];

    gbn_ram #(.Width(CornerBits), .Depth(MaxBoxes)) u_corner (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({i_in.left, i_in.top, i_in.right, i_in.bottom}),
        .i_raddr(w_raddr), .o_rdata(w_c));
    gbn_ram #(.Width(SlBits), .Depth(MaxBoxes)) u_score (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({i_in.confidence, i_in.class_tag}),
        .i_raddr(w_raddr), .o_rdata(w_sl));

    assign w_raddr     = r_idx;
    assign o_in_ready  = (r_state == StLoad);
    assign o_cfg_ready = (r_state == StLoad);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign w_emit      = r_pend && (!r_ov || i_out_ready)
                         && ((r_state == StEmit) || (r_state == StDone));

    // unpack corners
    logic [CoordBits-1:0] ka_l, ka_t, ka_r, ka_b, b_l, b_t, b_r, b_b;
    assign {ka_l, ka_t, ka_r, ka_b} = r_kc;
    assign {b_l, b_t, b_r, b_b}     = w_c;

    logic signed [SideBits-1:0] w_bw, w_bh, w_iw, w_ih;
    logic [CoordBits-1:0] mn_r, mx_l, mn_b, mx_t;
    assign mn_r = (ka_r < b_r) ? ka_r : b_r;
    assign mx_l = (ka_l > b_l) ? ka_l : b_l;
    assign mn_b = (ka_b < b_b) ? ka_b : b_b;
    assign mx_t = (ka_t > b_t) ? ka_t : b_t;
    assign w_iw = $signed({2'b00, mn_r}) - $signed({2'b00, mx_l}) + SideBits'(1);
    assign w_ih = $signed({2'b00, mn_b}) - $signed({2'b00, mx_t}) + SideBits'(1);
    assign w_bw = $signed({2'b00, b_r}) - $signed({2'b00, b_l}) + SideBits'(1);
    assign w_bh = $signed({2'b00, b_b}) - $signed({2'b00, b_t}) + SideBits'(1);

    // shared multiplier
    logic signed [SideBits:0]   w_ma, w_mb;
    logic signed [AreaBits+1:0] w_prod;
    logic signed [AreaBits+1:0] w_uni;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_ph)
            3'd1:    begin w_ma = {r_iw[SideBits-1], r_iw}; w_mb = {r_ih[SideBits-1], r_ih}; end
            3'd0:    begin w_ma = {w_bw[SideBits-1], w_bw}; w_mb = {w_bh[SideBits-1], w_bh}; end
            default: begin w_ma = {w_bw[SideBits-1], w_bw}; w_mb = {w_bh[SideBits-1], w_bh}; end
        endcase
    end
    assign w_prod = (AreaBits+2)'(w_ma * w_mb);
    assign w_uni  = r_sum - $signed({2'b00, r_inter});
    logic [AreaBits+17:0] w_rhs;
    assign w_rhs = (AreaBits+18)'(r_thr) * (AreaBits+18)'(w_uni[AreaBits:0]);

    logic w_kill;
    assign w_kill = (r_iw > 0) && (r_ih > 0) && (r_sum > $signed({2'b00, r_inter}))
                    && (r_lhs > w_rhs);

    logic [MaxBoxes-1:0] w_onehot_idx, w_onehot_best;
    assign w_onehot_idx  = MaxBoxes'(1) << r_idx;
    assign w_onehot_best = MaxBoxes'(1) << r_best;

    logic w_last_entry;
    assign w_last_entry = ({1'b0, r_idx} == r_count - CntBits'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StLoad;
            r_thr   <= ThrBits'(19661);
            r_count <= '0;
            r_supp  <= '0;
            r_idx   <= '0;
            r_ph    <= '0;
            r_found <= 1'b0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) r_thr <= i_cfg_data;
            unique case (r_state)
                StLoad: begin
                    if (i_in_valid) begin
                        if (r_count < CntBits'(MaxBoxes)) begin
                            r_count <= r_count + CntBits'(1);
                            r_supp  <= r_supp & ~(MaxBoxes'(1) << w_waddr);
                        end
                        if (i_in.final_box) begin
                            r_state <= StScan;
                            r_idx   <= '0;
                            r_ph    <= '0;
                            r_found <= 1'b0;
                        end
                    end
                end
                StScan: begin
                    // ph 0: address set; ph 1: data back
                    if (r_count == '0) begin
                        r_state <= StDone;
                    end else if (r_ph == 3'd0) begin
                        r_ph <= 3'd1;
                    end else begin
                        if (!(|(r_supp & w_onehot_idx)) &&
                            (!r_found || w_sl[SlBits-1 -: ScoreBits] > r_best_score)) begin
                            r_found      <= 1'b1;
                            r_best       <= r_idx;
                            r_best_score <= w_sl[SlBits-1 -: ScoreBits];
                        end
                        r_ph <= 3'd0;
                        if (w_last_entry) begin
                            r_state <= StKeep;
                        end else begin
                            r_idx <= r_idx + IdxBits'(1);
                        end
                    end
                end
                StKeep: begin
                    if (!r_found) begin
                        r_state <= StDone;
                    end else if (r_ph == 3'd0) begin
                        r_idx <= r_best;
                        r_ph  <= 3'd1;
                    end else if (r_ph == 3'd1) begin
                        r_ph <= 3'd2;
                    end else begin
                        r_kc  <= w_c;
                        r_ksl <= w_sl;
                        r_supp <= r_supp | w_onehot_best;
                        r_idx <= '0;
                        r_ph  <= 3'd0;
                        r_state <= StTest;
                    end
                end
                StTest: begin
                    unique case (r_ph)
                        3'd0: r_ph <= 3'd7;
                        3'd7: begin
                            r_iw <= w_iw;
                            r_ih <= w_ih;
                            r_barea <= AreaBits'(w_prod);
                            r_ph <= 3'd1;
                        end
                        3'd1: begin
                            r_inter <= AreaBits'(w_prod);
                            r_sum   <= $signed({{2{r_karea[AreaBits-1]}}, r_karea})
                                       + $signed({{2{r_barea[AreaBits-1]}}, r_barea});
                            r_ph <= 3'd2;
                        end
                        3'd2: begin
                            r_lhs <= {2'b00, r_inter, 16'd0};
                            r_ph <= 3'd3;
                        end
                        default: begin
                            if (!(|(r_supp & w_onehot_idx)) && w_kill)
                                r_supp <= r_supp | w_onehot_idx;
                            r_ph <= 3'd0;
                            if (w_last_entry) begin
                                r_state <= StEmit;
                            end else begin
                                r_idx <= r_idx + IdxBits'(1);
                            end
                        end
                    endcase
                end
                StEmit: begin
                    // hold a kept box until the next one shows it was not last
                    if (!r_ov || i_out_ready) begin
                        if (r_pend) begin
                            r_out <= r_pend_out;
                        end
                        r_pend <= 1'b1;
                        r_pend_out <= '{load_index: r_best,
                            kept_left: r_kc[CornerBits-1 -: CoordBits],
                            kept_top: r_kc[3*CoordBits-1 -: CoordBits],
                            kept_right: r_kc[2*CoordBits-1 -: CoordBits],
                            kept_bottom: r_kc[CoordBits-1:0],
                            kept_confidence: r_ksl[SlBits-1 -: ScoreBits],
                            kept_class: r_ksl[ClassBits-1:0],
                            last_kept: 1'b0};
                        r_idx   <= '0;
                        r_ph    <= '0;
                        r_found <= 1'b0;
                        r_state <= StScan;
                    end
                end
                StDone: begin
                    if (!r_ov || i_out_ready) begin
                        if (r_pend) begin
                            r_out <= {r_pend_out[$bits(t_box_out)-1:1], 1'b1};
                        end
                        r_pend  <= 1'b0;
                        r_count <= '0;
                        r_supp  <= '0;
                        r_state <= StLoad;
                    end
                end
                default: r_state <= StLoad;
            endcase
        end
    end

    // kept box area, taken from the shared multiplier while the kept box is latched
    always_ff @(posedge i_clk) begin
        if (r_state == StKeep && r_ph == 3'd2) begin
            r_karea <= AreaBits'(w_prod);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != StLoad |-> !o_in_ready)
        else $error("ready during suppression");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(MaxBoxes))
        else $error("box count overflow");
endmodule
`default_nettype wire

### rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gbn_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### tb/greedy_box_nms_test.sv
// Self-checking bench for greedy_box_nms: loads box sets, predicts the kept boxes in order
// with a local greedy suppression model, and compares each output transfer.
// Depends on gbn_pkg and the greedy_box_nms RTL.
`default_nettype none

class nms_scoreboard;
    typedef struct {
        int unsigned l, t, r, b, score, tag;
    } box_rec_t;

    box_rec_t          boxes[$];
    gbn_pkg::t_box_out kept_q[$];
    int unsigned       thresh = 19661;
    int                errors = 0;

    function bit overlaps(box_rec_t a, box_rec_t c);
        longint iw, ih, inter, sum, area_a, area_c;
        iw = longint'((a.r < c.r) ? a.r : c.r) - longint'((a.l > c.l) ? a.l : c.l) + 1;
        ih = longint'((a.b < c.b) ? a.b : c.b) - longint'((a.t > c.t) ? a.t : c.t) + 1;
        if (iw <= 0 || ih <= 0) return 0;
        inter = iw * ih;
        area_a = (longint'(a.r) - longint'(a.l) + 1) * (longint'(a.b) - longint'(a.t) + 1);
        area_c = (longint'(c.r) - longint'(c.l) + 1) * (longint'(c.b) - longint'(c.t) + 1);
        sum = area_a + area_c;
        if (sum <= inter) return 0;
        return inter * 65536 > longint'(thresh) * (sum - inter);
    endfunction

    function void note_box(gbn_pkg::t_box_in x);
        box_rec_t rec;
        bit       gone[$];
        int       best, n, first;
        gbn_pkg::t_box_out o;
        if (boxes.size() < gbn_pkg::MaxBoxes) begin
            rec = '{x.left, x.top, x.right, x.bottom, x.confidence, x.class_tag};
            boxes = {boxes, rec};
        end
        if (!x.final_box) return;
        n = boxes.size();
        for (int i = 0; i < n; i++) gone = {gone, 1'b0};
        first = kept_q.size();
        forever begin
            best = -1;
            for (int i = 0; i < n; i++)
                if (!gone[i] && (best < 0 || boxes[i].score > boxes[best].score)) best = i;
            if (best < 0) break;
            gone[best] = 1;
            for (int i = 0; i < n; i++)
                if (!gone[i] && overlaps(boxes[best], boxes[i])) gone[i] = 1;
            o.load_index      = best[gbn_pkg::IdxBits-1:0];
            o.kept_left       = boxes[best].l[gbn_pkg::CoordBits-1:0];
            o.kept_top        = boxes[best].t[gbn_pkg::CoordBits-1:0];
            o.kept_right      = boxes[best].r[gbn_pkg::CoordBits-1:0];
            o.kept_bottom     = boxes[best].b[gbn_pkg::CoordBits-1:0];
            o.kept_confidence = boxes[best].score[gbn_pkg::ScoreBits-1:0];
            o.kept_class      = boxes[best].tag[gbn_pkg::ClassBits-1:0];
            o.last_kept       = 0;
            kept_q = {kept_q, o};
        end
        if (kept_q.size() > first) kept_q[kept_q.size()-1].last_kept = 1;
        boxes.delete();
    endfunction

    function void check_kept(gbn_pkg::t_box_out got);
        gbn_pkg::t_box_out want;
        if (kept_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected kept box %h", got);
            return;
        end
        want = kept_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) $display("kept box mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module greedy_box_nms_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gbn_pkg::*;

    localparam int StallLimit = 200000;

    logic     i_clk = 0, i_rst_n = 0;
    logic     i_in_valid = 0, o_in_ready;
    t_box_in  i_in = '0;
    logic     o_out_valid, i_out_ready = 0;
    t_box_out o_out;
    logic     i_cfg_valid = 0, o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    nms_scoreboard kept_board = new();
    bit quiet_sink = 0;
    int idle_cycles = 0;

    greedy_box_nms dut (.*);

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) kept_board.check_kept(o_out);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sink side: random stall bursts
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet_sink && $urandom_range(0, 1)) begin
                gap = $urandom_range(1, 14);
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    bit quiet_src = 0;

    // hold valid across back-to-back transfers; drop it only for an idle burst
    task automatic send_box(t_box_in x);
        if (!quiet_src && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        kept_board.note_box(x);
    endtask

    task automatic drain_all();
        i_in_valid <= 0;
        while (kept_board.kept_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_thresh(logic [15:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        kept_board.thresh = v;
        i_cfg_valid <= 0;
    endtask

    function automatic t_box_in rand_box(bit fin, int unsigned span);
        t_box_in x;
        int unsigned cx, cy, rx, ry;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        rx = cx + $urandom_range(0, span);
        ry = cy + $urandom_range(0, span);
        x.left = CoordBits'(cx);
        x.top = CoordBits'(cy);
        x.right = CoordBits'((rx > 4095) ? 4095 : rx);
        x.bottom = CoordBits'((ry > 4095) ? 4095 : ry);
        if ($urandom_range(0, 9) == 0) begin
            x.left = CoordBits'($urandom);
            x.top = CoordBits'($urandom);
            x.right = CoordBits'($urandom);
            x.bottom = CoordBits'($urandom);
        end
        x.confidence = ScoreBits'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom);
        x.class_tag = ClassBits'($urandom);
        x.final_box = fin;
        return x;
    endfunction

    // cluster boxes around a seed so suppression actually triggers
    function automatic t_box_in near_box(t_box_in s, bit fin);
        t_box_in x;
        x = s;
        x.left = CoordBits'((s.left > 20) ? s.left - $urandom_range(0, 20) : s.left);
        x.top = CoordBits'((s.top > 20) ? s.top - $urandom_range(0, 20) : s.top);
        x.right = CoordBits'((s.right < 4075) ? s.right + $urandom_range(0, 20) : s.right);
        x.bottom = CoordBits'((s.bottom < 4075) ? s.bottom + $urandom_range(0, 20) : s.bottom);
        x.confidence = ScoreBits'($urandom);
        x.class_tag = ClassBits'($urandom);
        x.final_box = fin;
        return x;
    endfunction

    initial begin
        t_box_in b, seed;
        int sent, n;
        logic [15:0] thr_list[5] = '{16'd19661, 16'd0, 16'hFFFF, 16'd32768, 16'd1};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, equal scores, degenerate, single box, overflow
        b = '{12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF, 8'hFF, 1'b0}; send_box(b);
        b = '{12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF, 8'h00, 1'b0}; send_box(b);
        b = '{12'd10, 12'd10, 12'd20, 12'd20, 16'd0, 8'h55, 1'b0}; send_box(b);
        b = '{12'd30, 12'd30, 12'd5, 12'd5, 16'd100, 8'hAA, 1'b0}; send_box(b);
        b = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'd100, 8'h01, 1'b0}; send_box(b);
        b = '{12'd4095, 12'd4095, 12'd0, 12'd0, 16'd7, 8'h02, 1'b1}; send_box(b);
        drain_all();
        b = '{12'd100, 12'd200, 12'd100, 12'd200, 16'h8000, 8'h33, 1'b1}; send_box(b);
        drain_all();
        for (int i = 0; i < 66; i++) begin
            b = rand_box(i == 65, 300);
            if (i < 3) b.confidence = 16'd500;
            send_box(b);
        end
        sent = 73;
        drain_all();

        for (int ph = 0; ph < 5; ph++) begin
            write_thresh(thr_list[ph]);
            if (ph == 4) begin
                quiet_src = 1;
                quiet_sink = 1;
            end
            repeat (6) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
                seed = rand_box(0, 400);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 2) != 0) b = near_box(seed, i == n - 1);
                    else b = rand_box(i == n - 1, 600);
                    if ($urandom_range(0, 3) == 0) seed = b;
                    send_box(b);
                    sent++;
                end
            end
            drain_all();
        end
        write_thresh(16'($urandom));
        for (int i = 0; i < 8; i++) send_box(rand_box(i == 7, 800));
        drain_all();

        if (kept_board.errors == 0 && kept_board.kept_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire

### greedy_box_nms.f
rtl/gbn_pkg.sv
rtl/gbn_ram.sv
rtl/greedy_box_nms.sv
tb/greedy_box_nms_test.sv
